/* rtl/core/petsf_pkg.sv */
package petsf_pkg;

	// Default build parameters of the block.
	localparam int MAX_WINDOW_DEF  = 256;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int INDEX_BITS_DEF  = 24;

	// Fixed widths of the register fields.
	localparam int COEF_W    = 16;
	localparam int FRAC_BITS = 14;
	localparam int WLEN_W    = 9;
	localparam int CAP_W     = 42;
	localparam int CFG_IDX_W = 2;

	// Register indexes on the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_COEF   = 2'd0,
		CFG_WINDOW = 2'd1,
		CFG_CAP    = 2'd2
	} cfg_idx_t;

	// Sequencer steps for one item.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRED,
		ST_SQ,
		ST_ACC,
		ST_EVAL
	} seq_state_t;

	// Search progress within one record.
	typedef enum logic [1:0] {
		PH_SEEK_START,
		PH_SEEK_END,
		PH_DONE
	} phase_t;

endpackage

/* rtl/core/prediction_error_tone_segment_finder_unit.sv */
// Tone segment finder by second-order prediction error.
// Samples arrive on the input channel (in_valid, in_stall, sample, last_sample).
// Each sample is predicted from the two before it with a resonator; the squared
// residual feeds a sliding window sum, which is compared against the cap register to
// locate the start and end of a tone. One item is produced on the output
// channel (out_valid, out_stall) for every sample marked last_sample.
// Each sample is accepted in ST_IDLE, which reads the error ring. The shared
// multiplier forms the prediction product in ST_PRED and the squared residual
// in ST_SQ, where the old entry leaves the window sum; ST_ACC adds the new error
// and writes the ring, and ST_EVAL runs the threshold search. in_stall is high
// from ST_PRED to ST_EVAL; out_valid is loaded in ST_EVAL of a last sample.
// If the previous result is still stalled at the output when a new result is
// ready, the sequencer waits in its search step until the output register frees.
// Configuration registers are written through cfg_valid/cfg_index/cfg_data and
// are taken in any cycle (cfg_ready is always high); write them only while idle.
// Reset clears all record state and sets coef 0, window 2, cap 0. The error
// ring needs no clearing: each record only reads entries it has written.
module prediction_error_tone_segment_finder_unit
	import petsf_pkg::*;
#(
	parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int INDEX_BITS  = INDEX_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration write channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CAP_W-1:0]              cfg_data,
	// Sample channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          last_sample,
	// Result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          start_found,
	output logic [INDEX_BITS-1:0]         start_index,
	output logic                          end_found,
	output logic [INDEX_BITS:0]           end_index
);

	localparam int R_W    = SAMPLE_BITS + 2;
	localparam int MUL_W  = (COEF_W > R_W) ? COEF_W : R_W;
	localparam int PROD_W = 2 * MUL_W;
	localparam int ERR_W  = 2 * SAMPLE_BITS + 3;
	localparam int PTR_W  = $clog2(MAX_WINDOW);
	localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W  = ERR_W + PTR_W;
	localparam int CMP_W  = (SUM_W > CAP_W) ? SUM_W : CAP_W;
	localparam int EW     = (LEN_W > WLEN_W + 1) ? LEN_W : WLEN_W + 1;
	localparam int AW     = LEN_W + 1;
	localparam int KW     = ((INDEX_BITS > LEN_W) ? INDEX_BITS : LEN_W) + 1;
	localparam int TOP    = (MAX_WINDOW / 2) * 2;

	// Configuration registers
	logic signed [COEF_W-1:0] coef_q;
	logic [WLEN_W-1:0]        wlen_q;
	logic [CAP_W-1:0]         cap_q;

	// Sequencer and record state
	seq_state_t               state_q, state_d;
	phase_t                   phase_q;
	logic signed [SAMPLE_BITS-1:0] s_q, prev_q, sbp_q;
	logic                     last_q;
	logic [INDEX_BITS-1:0]    n_q;
	logic [LEN_W-1:0]         len_q, len_use;
	logic [LEN_W-1:0]         fill_q;
	logic [PTR_W-1:0]         pos_q;
	logic [SUM_W-1:0]         sum_q;
	logic [INDEX_BITS-1:0]    fstart_q;
	logic [INDEX_BITS:0]      fend_q;
	logic signed [PROD_W-1:0] mul_q;

	// Output register
	logic                     out_valid_q;
	logic                     start_found_q, end_found_q;
	logic [INDEX_BITS-1:0]    start_index_q;
	logic [INDEX_BITS:0]      end_index_q;

	// Datapath nets
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] mul_p;
	logic signed [PROD_W-1:0] pred, resid;
	logic [EW-1:0]            w_raw, w_even;
	logic [LEN_W-1:0]         eff_len;
	logic [AW-1:0]            rd_wide;
	logic [PTR_W-1:0]         rd_addr;
	logic [ERR_W-1:0]         rd_data, err;
	logic                     has_old;
	logic [ERR_W-1:0]         old;
	logic                     in_acc, eval_go, out_load, eval_ok;
	logic [CMP_W-1:0]         sum_ext, cap_ext;
	logic [KW-1:0]            k_wide, kend_wide;
	logic [INDEX_BITS-1:0]    k_idx;
	phase_t                   phase_mid, phase_new;

	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && !in_stall;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
			wlen_q <= WLEN_W'(2);
			cap_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_COEF:   coef_q <= cfg_data[COEF_W-1:0];
				CFG_WINDOW: wlen_q <= cfg_data[WLEN_W-1:0];
				CFG_CAP:    cap_q  <= cfg_data;
				default:    ;
			endcase
		end
	end

	// Effective window length: at least 2, even, at most the ring size.
	always_comb begin
		w_raw = EW'(wlen_q);
		if (w_raw < EW'(2)) begin
			w_raw = EW'(2);
		end
		w_even = w_raw + EW'(w_raw[0]);
		if (w_even > EW'(TOP)) begin
			w_even = EW'(TOP);
		end
		eff_len = w_even[LEN_W-1:0];
	end

	assign len_use = (n_q == '0) ? eff_len : len_q;

	// Ring read address: the entry that drops out of the window.
	always_comb begin
		if (AW'(pos_q) >= AW'(len_use)) begin
			rd_wide = AW'(pos_q) - AW'(len_use);
		end else begin
			rd_wide = AW'(pos_q) + AW'(MAX_WINDOW) - AW'(len_use);
		end
		rd_addr = rd_wide[PTR_W-1:0];
	end

	petsf_ram #(
		.WIDTH(ERR_W),
		.DEPTH(MAX_WINDOW)
	) u_ring (
		.clk     (clk),
		.wr_en   (state_q == ST_ACC),
		.wr_addr (pos_q),
		.wr_data (err),
		.rd_en   (in_acc),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Prediction rounded half up, and the residual that gets squared.
	assign pred  = (mul_q + (PROD_W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
	assign resid = PROD_W'(s_q) + PROD_W'(sbp_q) - pred;

	// Shared multiplier: coefficient times previous sample, then residual squared.
	always_comb begin
		if (state_q == ST_SQ) begin
			mul_a = resid[MUL_W-1:0];
			mul_b = resid[MUL_W-1:0];
		end else begin
			mul_a = MUL_W'(coef_q);
			mul_b = MUL_W'(prev_q);
		end
		mul_p = mul_a * mul_b;
	end

	assign has_old = fill_q >= len_q;
	assign old     = has_old ? rd_data : '0;
	assign err     = (n_q >= INDEX_BITS'(2)) ? mul_q[ERR_W-1:0] : '0;

	// Threshold search on the updated window sum.
	assign sum_ext   = CMP_W'(sum_q);
	assign cap_ext   = CMP_W'(cap_q);
	assign eval_ok   = (fill_q >= len_q) && !last_q && (cap_q != '0);
	assign k_wide    = (KW'(n_q) >= KW'(len_q) - KW'(1)) ?
		(KW'(n_q) - KW'(len_q) + KW'(1)) : '0;
	assign k_idx     = k_wide[INDEX_BITS-1:0];
	assign kend_wide = KW'(k_idx) + KW'(len_q);

	always_comb begin
		phase_mid = phase_q;
		if (eval_ok && phase_q == PH_SEEK_START && sum_ext <= cap_ext) begin
			phase_mid = PH_SEEK_END;
		end
		phase_new = phase_mid;
		if (eval_ok && phase_mid == PH_SEEK_END && sum_ext >= cap_ext) begin
			phase_new = PH_DONE;
		end
	end

	// Sequencer next state and handshake
	assign eval_go  = (state_q == ST_EVAL) && !(last_q && out_valid_q && out_stall);
	assign out_load = eval_go && last_q;

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = ST_PRED;
				end
			end
			ST_PRED: state_d = ST_SQ;
			ST_SQ:   state_d = ST_ACC;
			ST_ACC:  state_d = ST_EVAL;
			ST_EVAL: begin
				if (eval_go) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Item capture and shared multiplier result
	always_ff @(posedge clk) begin
		if (in_acc) begin
			s_q    <= sample;
			last_q <= last_sample;
		end
		if (state_q == ST_PRED || state_q == ST_SQ) begin
			mul_q <= mul_p;
		end
	end

	// Record state: window, ring pointer, history and search results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= LEN_W'(2);
			fill_q   <= '0;
			pos_q    <= '0;
			sum_q    <= '0;
			prev_q   <= '0;
			sbp_q    <= '0;
			n_q      <= '0;
			phase_q  <= PH_SEEK_START;
			fstart_q <= '0;
			fend_q   <= '0;
		end else begin
			if (in_acc) begin
				len_q <= len_use;
			end
			if (state_q == ST_SQ) begin
				sum_q <= sum_q - SUM_W'(old);
				if (!has_old) begin
					fill_q <= fill_q + LEN_W'(1);
				end
			end
			if (state_q == ST_ACC) begin
				sum_q  <= sum_q + SUM_W'(err);
				pos_q  <= (pos_q == PTR_W'(MAX_WINDOW - 1)) ? '0 : pos_q + PTR_W'(1);
				sbp_q  <= prev_q;
				prev_q <= s_q;
			end
			if (eval_go) begin
				if (last_q) begin
					len_q    <= LEN_W'(2);
					fill_q   <= '0;
					pos_q    <= '0;
					sum_q    <= '0;
					prev_q   <= '0;
					sbp_q    <= '0;
					n_q      <= '0;
					phase_q  <= PH_SEEK_START;
					fstart_q <= '0;
					fend_q   <= '0;
				end else begin
					phase_q <= phase_new;
					if (phase_q == PH_SEEK_START && phase_mid == PH_SEEK_END) begin
						fstart_q <= k_idx;
					end
					if (phase_mid == PH_SEEK_END && phase_new == PH_DONE) begin
						fend_q <= kend_wide[INDEX_BITS:0];
					end
					if (n_q != '1) begin
						n_q <= n_q + INDEX_BITS'(1);
					end
				end
			end
		end
	end

	// Output register, free to refill once the receiver takes the item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			start_found_q <= (cap_q != '0) && (phase_q != PH_SEEK_START);
			end_found_q   <= (cap_q != '0) && (phase_q == PH_DONE);
			start_index_q <= ((cap_q != '0) && (phase_q != PH_SEEK_START)) ? fstart_q : '0;
			end_index_q   <= ((cap_q != '0) && (phase_q == PH_DONE)) ? fend_q : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign start_found = start_found_q;
	assign start_index = start_index_q;
	assign end_found   = end_found_q;
	assign end_index   = end_index_q;

	// A result appears only after the search step of a final sample.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_EVAL && last_q))
		else $error("result raised without a final sample");

	// The fill count never runs past the latched window length.
	assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= len_q)
		else $error("ring fill count exceeds window length");

	// The ring pointer stays inside the ring.
	assert property (@(posedge clk) disable iff (!arst_n)
		AW'(pos_q) < AW'(MAX_WINDOW))
		else $error("ring pointer out of range");

	// No new item is taken while the sequencer is busy with one.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_PRED) && in_stall)
		else $error("item accepted while sequencer busy");

endmodule

/* rtl/core/petsf_ram.sv */
module petsf_ram #(
	parameter int WIDTH = 35,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
